/* hdl/sfd_pkg.sv */
// shared types, codes and reset constants of the fan duty controller
package sfd_pkg;

	// event kinds
	localparam logic [2:0] EV_TICK       = 3'd0;
	localparam logic [2:0] EV_SET_MANUAL = 3'd1;
	localparam logic [2:0] EV_PRESET     = 3'd2;
	localparam logic [2:0] EV_POWER      = 3'd3;
	localparam logic [2:0] EV_SET_MODE   = 3'd4;

	// operating modes
	localparam logic [1:0] FAN_OFF    = 2'd0;
	localparam logic [1:0] FAN_AUTO   = 2'd1;
	localparam logic [1:0] FAN_MANUAL = 2'd2;

	// manual preset slots
	localparam logic [1:0] SLOT_LOW    = 2'd0;
	localparam logic [1:0] SLOT_MED    = 2'd1;
	localparam logic [1:0] SLOT_HIGH   = 2'd2;
	localparam logic [1:0] SLOT_CUSTOM = 2'd3;

	// register indexes
	localparam logic [2:0] REG_PWM_MAX   = 3'd0;
	localparam logic [2:0] REG_SLEW      = 3'd1;
	localparam logic [2:0] REG_AUTO_CEIL = 3'd2;
	localparam logic [2:0] REG_MIN_ACT   = 3'd3;
	localparam logic [2:0] REG_MAN_CEIL  = 3'd4;
	localparam logic [2:0] REG_FALLBACK  = 3'd5;
	localparam logic [2:0] REG_BUCKETS   = 3'd6;
	localparam logic [2:0] REG_PRESETS   = 3'd7;

	localparam int unsigned APB_AW = 6;
	localparam int unsigned APB_DW = 64;

	localparam logic [6:0] FULL_PCT   = 7'd100;
	localparam logic [7:0] TOP_BUCKET = 8'd5;

	// register reset values
	localparam logic [15:0] RST_PWM_MAX   = 16'd255;
	localparam logic [6:0]  RST_SLEW      = 7'd5;
	localparam logic [6:0]  RST_AUTO_CEIL = 7'd80;
	localparam logic [6:0]  RST_MIN_ACT   = 7'd20;
	localparam logic [6:0]  RST_MAN_CEIL  = 7'd100;
	localparam logic [6:0]  RST_FALLBACK  = 7'd50;
	localparam logic [47:0] RST_BUCKETS   = 48'h5A4B3C2D1E14;
	localparam logic [23:0] RST_PRESETS   = 24'h50321E;

	// state reset: medium preset and bucket zero of the reset tables
	localparam logic [6:0] RST_MANUAL_LEVEL = 7'd50;
	localparam logic [6:0] RST_TARGET_LEVEL = 7'd20;

	// floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 2^23
	localparam logic [23:0] RECIP_100   = 24'd10737419;
	localparam int unsigned RECIP_SHIFT = 30;

	typedef struct packed {
		logic [15:0] pwm_max_ticks;
		logic [6:0]  slew_step;
		logic [6:0]  auto_ceiling;
		logic [6:0]  min_active;
		logic [6:0]  manual_ceiling;
		logic [6:0]  fallback_pct;
		logic [47:0] bucket_table;
		logic [23:0] preset_table;
	} cfg_t;

	// state snapshot after one event, handed to the pwm stages
	typedef struct packed {
		logic [6:0]  duty;
		logic [6:0]  target;
		logic [1:0]  mode;
		logic [1:0]  slot;
		logic [15:0] max_ticks;
	} step_res_t;

endpackage

/* hdl/sfd_ifs.sv */
// event and result channel interfaces
interface sfd_in_if;
	logic              valid;
	logic              ready;
	logic [2:0]        mode;
	logic signed [7:0] aqi_bucket;
	logic              sensor_fault;
	logic [7:0]        duty_request;
	logic [1:0]        requested_mode;

	modport source (output valid, mode, aqi_bucket, sensor_fault, duty_request,
		requested_mode, input ready);
	modport sink (input valid, mode, aqi_bucket, sensor_fault, duty_request,
		requested_mode, output ready);
endinterface

interface sfd_out_if;
	logic        valid;
	logic        ready;
	logic [6:0]  duty_pct;
	logic [15:0] pwm_ticks;
	logic [6:0]  target_pct;
	logic [1:0]  mode_now;
	logic [1:0]  preset_now;

	modport source (output valid, duty_pct, pwm_ticks, target_pct, mode_now,
		preset_now, input ready);
	modport sink (input valid, duty_pct, pwm_ticks, target_pct, mode_now,
		preset_now, output ready);
endinterface

/* hdl/sfd_regs.sv */
// apb configuration register file
module sfd_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfd_pkg::APB_AW-1:0]    paddr,
	input  logic [sfd_pkg::APB_DW-1:0]    pwdata,
	output logic [sfd_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	output sfd_pkg::cfg_t                 cfg
);
	import sfd_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[APB_AW-1:3];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_max_ticks  <= RST_PWM_MAX;
			cfg_q.slew_step      <= RST_SLEW;
			cfg_q.auto_ceiling   <= RST_AUTO_CEIL;
			cfg_q.min_active     <= RST_MIN_ACT;
			cfg_q.manual_ceiling <= RST_MAN_CEIL;
			cfg_q.fallback_pct   <= RST_FALLBACK;
			cfg_q.bucket_table   <= RST_BUCKETS;
			cfg_q.preset_table   <= RST_PRESETS;
		end else if (wr) begin
			case (idx)
				REG_PWM_MAX:   cfg_q.pwm_max_ticks  <= pwdata[15:0];
				REG_SLEW:      cfg_q.slew_step      <= pwdata[6:0];
				REG_AUTO_CEIL: cfg_q.auto_ceiling   <= pwdata[6:0];
				REG_MIN_ACT:   cfg_q.min_active     <= pwdata[6:0];
				REG_MAN_CEIL:  cfg_q.manual_ceiling <= pwdata[6:0];
				REG_FALLBACK:  cfg_q.fallback_pct   <= pwdata[6:0];
				REG_BUCKETS:   cfg_q.bucket_table   <= pwdata[47:0];
				REG_PRESETS:   cfg_q.preset_table   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PWM_MAX:   prdata = {48'd0, cfg_q.pwm_max_ticks};
			REG_SLEW:      prdata = {57'd0, cfg_q.slew_step};
			REG_AUTO_CEIL: prdata = {57'd0, cfg_q.auto_ceiling};
			REG_MIN_ACT:   prdata = {57'd0, cfg_q.min_active};
			REG_MAN_CEIL:  prdata = {57'd0, cfg_q.manual_ceiling};
			REG_FALLBACK:  prdata = {57'd0, cfg_q.fallback_pct};
			REG_BUCKETS:   prdata = {16'd0, cfg_q.bucket_table};
			REG_PRESETS:   prdata = {40'd0, cfg_q.preset_table};
			default:       prdata = '0;
		endcase
	end

endmodule

/* hdl/sfd_step.sv */
// input register, controller state and per-event next-state logic
module sfd_step (
	input  logic              clk,
	input  logic              arst_n,
	input  sfd_pkg::cfg_t     cfg,
	sfd_in_if.sink            in_ch,
	output logic              res_valid,
	input  logic              res_ready,
	output sfd_pkg::step_res_t res
);
	import sfd_pkg::*;

	function automatic logic [6:0] sat_pct(input logic [7:0] v);
		return (v > {1'b0, FULL_PCT}) ? FULL_PCT : v[6:0];
	endfunction

	// input stage
	logic              valid_s1;
	logic [2:0]        ev_s1;
	logic signed [7:0] bucket_s1;
	logic              fault_s1;
	logic [7:0]        req_s1;
	logic [1:0]        rmode_s1;

	// controller state
	logic [1:0] mode_q, last_on_q, slot_q;
	logic [6:0] manual_q, target_q, present_q;

	logic [1:0] mode_d, last_on_d, slot_d;
	logic [6:0] manual_d, target_d, present_d;

	logic      valid_s2;
	step_res_t res_s2;

	logic take2, take1, fire1;

	assign take2       = !valid_s2 || res_ready;
	assign take1       = !valid_s1 || take2;
	assign fire1       = valid_s1 && take2;
	assign in_ch.ready = take1;
	assign res_valid   = valid_s2;
	assign res         = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take1) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take1 && in_ch.valid) begin
			ev_s1     <= in_ch.mode;
			bucket_s1 <= in_ch.aqi_bucket;
			fault_s1  <= in_ch.sensor_fault;
			req_s1    <= in_ch.duty_request;
			rmode_s1  <= in_ch.requested_mode;
		end
	end

	// next state
	always_comb begin
		logic [6:0] lo, hi, d, cur, tgt, step;
		logic [7:0] sum, byte_sel, req;
		logic [2:0] bidx;
		logic [1:0] go;
		logic       go_en;

		mode_d    = mode_q;
		last_on_d = last_on_q;
		slot_d    = slot_q;
		manual_d  = manual_q;
		target_d  = target_q;
		present_d = present_q;
		go        = FAN_OFF;
		go_en     = 1'b0;
		lo        = sat_pct({1'b0, cfg.min_active});
		hi        = sat_pct({1'b0, cfg.auto_ceiling});
		d         = '0;
		cur       = present_q;
		tgt       = '0;
		sum       = '0;
		req       = req_s1;
		byte_sel  = '0;
		step      = cfg.slew_step;

		// saturate bucket to the table range
		if (bucket_s1[7]) begin
			bidx = 3'd0;
		end else if (bucket_s1 > $signed(TOP_BUCKET)) begin
			bidx = TOP_BUCKET[2:0];
		end else begin
			bidx = bucket_s1[2:0];
		end

		case (ev_s1)
			EV_TICK: begin
				if (mode_q == FAN_OFF) begin
					target_d = '0;
				end else if (fault_s1) begin
					target_d = sat_pct({1'b0, cfg.fallback_pct});
				end else if (mode_q == FAN_MANUAL) begin
					target_d = manual_q;
				end else begin
					case (bidx)
						3'd0:    byte_sel = cfg.bucket_table[7:0];
						3'd1:    byte_sel = cfg.bucket_table[15:8];
						3'd2:    byte_sel = cfg.bucket_table[23:16];
						3'd3:    byte_sel = cfg.bucket_table[31:24];
						3'd4:    byte_sel = cfg.bucket_table[39:32];
						default: byte_sel = cfg.bucket_table[47:40];
					endcase
					d = sat_pct(byte_sel);
					if (d > hi) d = hi;
					// minimum clamp last, wins over the ceiling
					if (d < lo) d = lo;
					target_d = d;
				end
				cur = present_q;
				tgt = target_d;
				sum = {1'b0, cur} + {1'b0, step};
				if (tgt > cur) begin
					present_d = (sum >= {1'b0, tgt}) ? tgt : sum[6:0];
				end else if (tgt < cur) begin
					present_d = (cur <= step || (cur - step) <= tgt) ? tgt : cur - step;
				end else begin
					present_d = tgt;
				end
			end
			EV_SET_MANUAL: begin
				hi = sat_pct({1'b0, cfg.manual_ceiling});
				if (req > {1'b0, hi}) req = {1'b0, hi};
				if (req < {1'b0, lo} && req != 8'd0) req = {1'b0, lo};
				manual_d = req[6:0];
				slot_d   = SLOT_CUSTOM;
				go       = FAN_MANUAL;
				go_en    = 1'b1;
			end
			EV_PRESET: begin
				if (mode_q != FAN_MANUAL) begin
					go       = FAN_MANUAL;
					go_en    = 1'b1;
					slot_d   = SLOT_LOW;
					manual_d = sat_pct(cfg.preset_table[7:0]);
				end else if (slot_q == SLOT_LOW) begin
					slot_d   = SLOT_MED;
					manual_d = sat_pct(cfg.preset_table[15:8]);
				end else if (slot_q == SLOT_MED) begin
					slot_d   = SLOT_HIGH;
					manual_d = sat_pct(cfg.preset_table[23:16]);
				end else begin
					go    = FAN_AUTO;
					go_en = 1'b1;
				end
			end
			EV_POWER: begin
				go_en = 1'b1;
				if (mode_q == FAN_OFF) begin
					go = (last_on_q == FAN_OFF) ? FAN_AUTO : last_on_q;
				end else begin
					go = FAN_OFF;
				end
			end
			EV_SET_MODE: begin
				if (rmode_s1 == FAN_OFF || rmode_s1 == FAN_AUTO ||
					rmode_s1 == FAN_MANUAL) begin
					go    = rmode_s1;
					go_en = 1'b1;
				end
			end
			default: ;
		endcase

		if (go_en && go != mode_q) begin
			if (go != FAN_OFF) last_on_d = go;
			mode_d = go;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= FAN_AUTO;
			last_on_q <= FAN_AUTO;
			slot_q    <= SLOT_MED;
			manual_q  <= RST_MANUAL_LEVEL;
			target_q  <= RST_TARGET_LEVEL;
			present_q <= '0;
			valid_s2  <= 1'b0;
		end else begin
			if (fire1) begin
				mode_q    <= mode_d;
				last_on_q <= last_on_d;
				slot_q    <= slot_d;
				manual_q  <= manual_d;
				target_q  <= target_d;
				present_q <= present_d;
			end
			if (take2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			res_s2.duty      <= present_d;
			res_s2.target    <= target_d;
			res_s2.mode      <= mode_d;
			res_s2.slot      <= slot_d;
			res_s2.max_ticks <= cfg.pwm_max_ticks;
		end
	end

endmodule

/* hdl/sfd_pwm.sv */
// pwm count: duty times full scale, then divide by 100, into the result register
module sfd_pwm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	output logic               res_ready,
	input  sfd_pkg::step_res_t res,
	sfd_out_if.source          out_ch
);
	import sfd_pkg::*;

	logic        valid_s3;
	logic [22:0] prod_s3;
	step_res_t   res_s3;

	logic        valid_q;
	logic [6:0]  duty_q, target_q;
	logic [15:0] ticks_q;
	logic [1:0]  mode_q, slot_q;

	logic        take_o, take3;
	logic [22:0] prod;
	logic [46:0] quot_full;

	assign take_o    = !valid_q || out_ch.ready;
	assign take3     = !valid_s3 || take_o;
	assign res_ready = take3;

	assign prod      = {16'd0, res.duty} * {7'd0, res.max_ticks};
	assign quot_full = {24'd0, prod_s3} * {23'd0, RECIP_100};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (take3)  valid_s3 <= res_valid;
			if (take_o) valid_q  <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (take3 && res_valid) begin
			prod_s3 <= prod;
			res_s3  <= res;
		end
		if (take_o && valid_s3) begin
			duty_q   <= res_s3.duty;
			target_q <= res_s3.target;
			mode_q   <= res_s3.mode;
			slot_q   <= res_s3.slot;
			ticks_q  <= quot_full[RECIP_SHIFT +: 16];
		end
	end

	assign out_ch.valid      = valid_q;
	assign out_ch.duty_pct   = duty_q;
	assign out_ch.pwm_ticks  = ticks_q;
	assign out_ch.target_pct = target_q;
	assign out_ch.mode_now   = mode_q;
	assign out_ch.preset_now = slot_q;

endmodule

/* hdl/slew_limited_fan_duty_controller.sv */
// top level of the slew limited fan duty controller
//
//  channel  role    transfer when          carries
//  in_ch    sink    valid && ready          one event: kind, bucket, fault, request, mode
//  out_ch   source  valid && ready          one result: duty, pwm count, target, mode, preset
//  apb      slave   psel&penable&pwrite     register write, 64-bit data, 8-byte stride
//
// one event per cycle sustained while out_ch accepts results; each event passes, in order, through the
// input register, state update, duty times full scale multiply, divide by 100 via a
// reciprocal multiply into the result register
// async active-low reset clears valids and loads state and register reset values
// each stage holds while its successor is full and stalled, so a stall on out_ch only backs up
// the pipeline as far as it is occupied
module slew_limited_fan_duty_controller (
	input  logic                       clk,
	input  logic                       arst_n,
	sfd_in_if.sink                     in_ch,
	sfd_out_if.source                  out_ch,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sfd_pkg::APB_AW-1:0] paddr,
	input  logic [sfd_pkg::APB_DW-1:0] pwdata,
	output logic [sfd_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import sfd_pkg::*;

	cfg_t      cfg;
	step_res_t res;
	logic      res_valid;
	logic      res_ready;

	// configuration registers; the user must write them only while idle, the block does not enforce it
	sfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// event decode and state update, one event per cycle unless the pwm stage backs up
	sfd_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_ch     (in_ch),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// pwm count arithmetic and result register
	sfd_pwm u_pwm (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.out_ch    (out_ch)
	);

endmodule
